// ===== hw/rtl/fat12_pkg.sv =====
// ----------------------------------------------------------------------------
// FAT12 cluster chain engine package
// Shared types, codes and helpers for the allocation table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fat12_pkg;

    localparam int TableEntriesDefault = 4096;
    localparam logic [11:0] EndMark  = 12'hFF8;
    localparam logic [11:0] BadMark  = 12'hFF7;
    localparam logic [12:0] LimitReset = 13'd4096;

    typedef enum logic [2:0] {
        FN_READ  = 3'd0,
        FN_WRITE = 3'd1,
        FN_ALLOC = 3'd2,
        FN_FREE  = 3'd3,
        FN_SEEK  = 3'd4,
        FN_TAIL  = 3'd5,
        FN_RUN   = 3'd6,
        FN_NONE  = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_LIMIT = 3'd2,
        ST_BAD   = 3'd3,
        ST_WP    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        K_LINK = 2'd0,
        K_END  = 2'd1,
        K_BAD  = 2'd2
    } kind_t;

    localparam logic [0:0] RegLimit = 1'b0;
    localparam logic [0:0] RegWen   = 1'b1;

    typedef struct packed {
        logic        wr;
        logic [11:0] addr;
        logic [11:0] data;
        logic        rd;
    } mem_req_t;

    function automatic kind_t kind_of(input logic [11:0] v, input logic [12:0] entries);
        kind_t k;
        if (v == 12'd0 || v >= EndMark)
            k = K_END;
        else if (v >= 12'd2 && v < BadMark && {1'b0, v} < entries)
            k = K_LINK;
        else
            k = K_BAD;
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fat12_table.sv =====
// ----------------------------------------------------------------------------
// FAT12 table memory
// Single-port synchronous memory holding one 12-bit entry per cluster.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12_table #(
    parameter int TABLE_ENTRIES = fat12_pkg::TableEntriesDefault
) (
    input  wire logic               clk,
    input  wire fat12_pkg::mem_req_t req,
    output logic [11:0]             rdata
);

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic [11:0] mem [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (req.wr)
            mem[req.addr[AW-1:0]] <= req.data;
        if (req.rd)
            rdata <= mem[req.addr[AW-1:0]];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fat12_ctrl.sv =====
// ----------------------------------------------------------------------------
// FAT12 operation sequencer
// Runs one operation at a time as read-modify-write steps on the table.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12_ctrl #(
    parameter int TABLE_ENTRIES = fat12_pkg::TableEntriesDefault
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [2:0]          in_func,
    input  wire logic [11:0]         in_cluster,
    input  wire logic [11:0]         in_value,
    input  wire logic [11:0]         in_count,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [2:0]               out_status,
    output logic [11:0]              out_cluster,
    output logic [11:0]              out_value,
    output logic [12:0]              out_count,
    input  wire logic [12:0]         limit,
    input  wire logic                wen,
    output fat12_pkg::mem_req_t      req,
    input  wire logic [11:0]         rdata
);

    localparam logic [12:0] Entries = 13'(TABLE_ENTRIES);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ISSUE  = 7'b0000010,
        S_WAIT   = 7'b0000100,
        S_ALLOC  = 7'b0001000,
        S_LINK   = 7'b0010000,
        S_APPEND = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  func_reg, func_next;
    logic [11:0] cl_reg, cl_next;
    logic [11:0] val_reg, val_next;
    logic [11:0] cnt_reg, cnt_next;
    logic [11:0] tail_reg, tail_next;
    logic [11:0] prev_reg, prev_next;
    logic [12:0] steps_reg, steps_next;
    logic [12:0] top_reg, top_next;
    logic [2:0]  st_reg, st_next;
    logic [11:0] clo_reg, clo_next;
    logic [11:0] vo_reg, vo_next;
    logic [12:0] co_reg, co_next;
    logic        ov_reg, ov_next;

    fat12_pkg::kind_t kcl, krd;
    logic [12:0] top_c;

    assign kcl = fat12_pkg::kind_of(cl_reg, Entries);
    assign krd = fat12_pkg::kind_of(rdata, Entries);
    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_status = st_reg;
    assign out_cluster = clo_reg;
    assign out_value = vo_reg;
    assign out_count = co_reg;

    always_comb
    begin
        top_c = limit;
        if (top_c > Entries)
            top_c = Entries;
        if (top_c > {1'b0, fat12_pkg::BadMark})
            top_c = {1'b0, fat12_pkg::BadMark};
    end

    always_comb
    begin
        state_next = state_reg;
        func_next = func_reg;
        cl_next = cl_reg;
        val_next = val_reg;
        cnt_next = cnt_reg;
        tail_next = tail_reg;
        prev_next = prev_reg;
        steps_next = steps_reg;
        top_next = top_reg;
        st_next = st_reg;
        clo_next = clo_reg;
        vo_next = vo_reg;
        co_next = co_reg;
        ov_next = ov_reg;
        req = '0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    func_next = in_func;
                    cl_next = in_cluster;
                    val_next = in_value;
                    cnt_next = in_count;
                    tail_next = in_cluster;
                    prev_next = 12'd0;
                    steps_next = 13'd0;
                    top_next = top_c;
                    st_next = fat12_pkg::ST_OK;
                    clo_next = 12'd0;
                    vo_next = 12'd0;
                    co_next = 13'd0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                state_next = S_WAIT;
                case (func_reg)
                    fat12_pkg::FN_READ, fat12_pkg::FN_WRITE:
                    begin
                        if (!wen && func_reg == fat12_pkg::FN_WRITE)
                        begin
                            st_next = fat12_pkg::ST_WP;
                            state_next = S_DONE;
                        end
                        else if ({1'b0, cl_reg} >= Entries)
                        begin
                            st_next = fat12_pkg::ST_BAD;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            clo_next = cl_reg;
                            req.addr = cl_reg;
                            req.data = val_reg;
                            req.wr = (func_reg == fat12_pkg::FN_WRITE);
                            req.rd = (func_reg == fat12_pkg::FN_READ);
                            state_next = req.wr ? S_DONE : S_WAIT;
                        end
                    end
                    fat12_pkg::FN_ALLOC:
                    begin
                        if (!wen)
                        begin
                            st_next = fat12_pkg::ST_WP;
                            state_next = S_DONE;
                        end
                        else if (tail_reg != 12'd0 && kcl != fat12_pkg::K_LINK)
                        begin
                            st_next = fat12_pkg::ST_BAD;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cl_next = 12'd2;
                            state_next = S_ALLOC;
                        end
                    end
                    fat12_pkg::FN_FREE, fat12_pkg::FN_TAIL:
                    begin
                        if (!wen && func_reg == fat12_pkg::FN_FREE)
                        begin
                            st_next = fat12_pkg::ST_WP;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            co_next = steps_reg;
                            clo_next = prev_reg;
                            if (kcl == fat12_pkg::K_END)
                                state_next = S_DONE;
                            else if (kcl == fat12_pkg::K_BAD)
                            begin
                                st_next = fat12_pkg::ST_BAD;
                                state_next = S_DONE;
                            end
                            else if (steps_reg >= Entries)
                            begin
                                st_next = fat12_pkg::ST_LIMIT;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                req.rd = 1'b1;
                                req.addr = cl_reg;
                            end
                        end
                    end
                    fat12_pkg::FN_SEEK:
                    begin
                        clo_next = cl_reg;
                        co_next = steps_reg;
                        if (steps_reg >= {1'b0, cnt_reg})
                            state_next = S_DONE;
                        else if (steps_reg >= Entries)
                        begin
                            st_next = fat12_pkg::ST_LIMIT;
                            state_next = S_DONE;
                        end
                        else if (kcl != fat12_pkg::K_LINK)
                        begin
                            if (kcl == fat12_pkg::K_BAD)
                                st_next = fat12_pkg::ST_BAD;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            req.rd = 1'b1;
                            req.addr = cl_reg;
                        end
                    end
                    fat12_pkg::FN_RUN:
                    begin
                        clo_next = cl_reg;
                        if (steps_reg == 13'd0)
                        begin
                            if (kcl == fat12_pkg::K_BAD)
                            begin
                                st_next = fat12_pkg::ST_BAD;
                                state_next = S_DONE;
                            end
                            else if (kcl != fat12_pkg::K_LINK || cnt_reg == 12'd0)
                                state_next = S_DONE;
                            else
                            begin
                                steps_next = 13'd1;
                                co_next = 13'd1;
                                state_next = S_ISSUE;
                            end
                        end
                        else
                        begin
                            co_next = steps_reg;
                            if (steps_reg >= {1'b0, cnt_reg})
                                state_next = S_DONE;
                            else
                            begin
                                req.rd = 1'b1;
                                req.addr = cl_reg;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_WAIT:
            begin
                state_next = S_ISSUE;
                case (func_reg)
                    fat12_pkg::FN_READ:
                    begin
                        vo_next = rdata;
                        state_next = S_DONE;
                    end
                    fat12_pkg::FN_FREE:
                    begin
                        req.wr = 1'b1;
                        req.addr = cl_reg;
                        req.data = 12'd0;
                        cl_next = rdata;
                        steps_next = steps_reg + 13'd1;
                    end
                    fat12_pkg::FN_TAIL:
                    begin
                        prev_next = cl_reg;
                        cl_next = rdata;
                        steps_next = steps_reg + 13'd1;
                    end
                    fat12_pkg::FN_SEEK:
                    begin
                        cl_next = rdata;
                        steps_next = steps_reg + 13'd1;
                    end
                    fat12_pkg::FN_RUN:
                    begin
                        if (rdata != cl_reg + 12'd1 || krd != fat12_pkg::K_LINK)
                            state_next = S_DONE;
                        else
                        begin
                            cl_next = rdata;
                            clo_next = rdata;
                            steps_next = steps_reg + 13'd1;
                            co_next = steps_reg + 13'd1;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_ALLOC:
            begin
                if ({1'b0, cl_reg} >= top_reg)
                begin
                    st_next = fat12_pkg::ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    req.rd = 1'b1;
                    req.addr = cl_reg;
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                if (rdata == 12'd0)
                begin
                    req.wr = 1'b1;
                    req.addr = cl_reg;
                    req.data = fat12_pkg::EndMark;
                    clo_next = cl_reg;
                    state_next = (tail_reg != 12'd0) ? S_APPEND : S_DONE;
                end
                else
                begin
                    cl_next = cl_reg + 12'd1;
                    state_next = (cl_reg == 12'hFFF) ? S_DONE : S_ALLOC;
                    if (cl_reg == 12'hFFF)
                        st_next = fat12_pkg::ST_FULL;
                end
            end
            S_APPEND:
            begin
                req.wr = 1'b1;
                req.addr = tail_reg;
                req.data = clo_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        cl_reg <= cl_next;
        val_reg <= val_next;
        cnt_reg <= cnt_next;
        tail_reg <= tail_next;
        prev_reg <= prev_next;
        steps_reg <= steps_next;
        top_reg <= top_next;
        st_reg <= st_next;
        clo_reg <= clo_next;
        vo_reg <= vo_next;
        co_reg <= co_next;
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE)) else $error("ready outside idle");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> ov_reg) else $error("result dropped");
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.wr && req.rd)) else $error("read and write together");
    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= Entries + 13'd1 || state_reg == S_IDLE) else $error("walk overran");

endmodule

`default_nettype wire

// ===== hw/rtl/fat12_cluster_chain_engine.sv =====
// ----------------------------------------------------------------------------
// FAT12 cluster chain engine
// Allocation table engine for a FAT12 volume with chain operations.
// ----------------------------------------------------------------------------
// Items arrive on the s_axis channel; each yields one result item on m_axis.
// The table is a single-port 4096 x 12 memory with a registered read port,
// and every chain step is a table read followed by a decision on the read
// data: a walk reads each link in turn, and an allocation scan reads and
// tests one cluster at a time and, when the new cluster is linked after a
// tail, ends with one more write of that tail entry.
// One item is in work at a time; s_axis_tready rises when the result register
// is free again. If the receiver stalls, the result holds in its register and
// no new item is taken. Reset sets cluster_limit to 4096 and write_enable to
// 1; the table contents are undefined until software writes every entry.
// Configuration writes on cfg_we take effect at the next edge.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12_cluster_chain_engine #(
    parameter int TABLE_ENTRIES = fat12_pkg::TableEntriesDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // func, cluster, value, count, zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // status, cluster_out, value_out, count_out
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [12:0] cfg_wdata
);

    logic [12:0] limit_reg;
    logic        wen_reg;
    fat12_pkg::mem_req_t req;
    logic [11:0] rdata;
    logic [2:0]  status;
    logic [11:0] cl_out, v_out;
    logic [12:0] c_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= fat12_pkg::LimitReset;
            wen_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == fat12_pkg::RegLimit)
                limit_reg <= cfg_wdata;
            else
                wen_reg <= cfg_wdata[0];
        end
    end

    fat12_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_func(s_axis_tdata[2:0]), .in_cluster(s_axis_tdata[14:3]),
        .in_value(s_axis_tdata[26:15]), .in_count(s_axis_tdata[38:27]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_status(status), .out_cluster(cl_out), .out_value(v_out),
        .out_count(c_out), .limit(limit_reg), .wen(wen_reg),
        .req(req), .rdata(rdata)
    );

    fat12_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
        .clk(clk), .req(req), .rdata(rdata)
    );

    assign m_axis_tdata = {c_out, v_out, cl_out, status};

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// FAT12 cluster chain engine testbench
// Loads the whole allocation table and then runs a table of directed items.
// Random phases follow under several cluster limits and write protect
// settings. Each result item is checked field by field against a predictor,
// or its row for typed directed items; random bursts, receiver stalls and
// one long receiver hold-off vary the traffic on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Entries     = 4096;
    localparam int IdleLimit   = 60000;
    localparam int LongHold    = 3000;
    localparam int PhaseItems  = 240;

    typedef struct packed {
        fat12_pkg::status_t st;
        logic [11:0]        clo;
        logic [11:0]        vo;
        logic [12:0]        co;
    } fat_result_t;

    typedef struct packed {
        fat12_pkg::func_t fn;
        logic [11:0]      cl;
        logic [11:0]      val;
        logic [11:0]      cnt;
        logic             typed;
        fat_result_t      res;
    } fat_op_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_we;
    logic        cfg_addr;
    logic [12:0] cfg_wdata;

    logic [11:0] fat_mirror [Entries];
    logic [12:0] mirror_limit;
    logic        mirror_wen;

    fat_result_t pending_results[$];
    fat_op_t     directed_ops[$];
    int          mismatches;
    int          idle_cycles;
    int          ops_accepted;
    bit          hold_done;

    fat12_cluster_chain_engine u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic fat12_pkg::kind_t link_class(input logic [11:0] v);
        fat12_pkg::kind_t k;
        if (v == 12'd0 || v >= fat12_pkg::EndMark)
            k = fat12_pkg::K_END;
        else if (v >= 12'd2 && v < fat12_pkg::BadMark)
            k = fat12_pkg::K_LINK;
        else
            k = fat12_pkg::K_BAD;
        return k;
    endfunction

    function automatic fat_result_t apply_fat_op(input fat_op_t op);
        fat_result_t      r;
        logic [11:0]      cur;
        logic [11:0]      prev;
        logic [11:0]      nxt;
        int               steps;
        int               top;
        int               c;
        fat12_pkg::kind_t k;
        r = '{fat12_pkg::ST_OK, 12'd0, 12'd0, 13'd0};
        cur = op.cl;
        prev = 12'd0;
        steps = 0;
        if (!mirror_wen && (op.fn == fat12_pkg::FN_WRITE || op.fn == fat12_pkg::FN_ALLOC
                            || op.fn == fat12_pkg::FN_FREE))
            r.st = fat12_pkg::ST_WP;
        else
        begin
            case (op.fn)
                fat12_pkg::FN_READ:
                begin
                    r.clo = op.cl;
                    r.vo = fat_mirror[op.cl];
                end
                fat12_pkg::FN_WRITE:
                begin
                    r.clo = op.cl;
                    fat_mirror[op.cl] = op.val;
                end
                fat12_pkg::FN_ALLOC:
                begin
                    if (op.cl != 12'd0 && link_class(op.cl) != fat12_pkg::K_LINK)
                        r.st = fat12_pkg::ST_BAD;
                    else
                    begin
                        top = int'(mirror_limit);
                        if (top > Entries)
                            top = Entries;
                        if (top > int'(fat12_pkg::BadMark))
                            top = int'(fat12_pkg::BadMark);
                        r.st = fat12_pkg::ST_FULL;
                        for (c = 2; c < top; c++)
                        begin
                            if (fat_mirror[c] == 12'd0)
                            begin
                                r.st = fat12_pkg::ST_OK;
                                break;
                            end
                        end
                        if (r.st == fat12_pkg::ST_OK)
                        begin
                            fat_mirror[c] = fat12_pkg::EndMark;
                            if (op.cl != 12'd0)
                                fat_mirror[op.cl] = c[11:0];
                            r.clo = c[11:0];
                        end
                    end
                end
                fat12_pkg::FN_FREE:
                begin
                    forever
                    begin
                        k = link_class(cur);
                        if (k == fat12_pkg::K_END)
                            break;
                        if (k == fat12_pkg::K_BAD)
                        begin
                            r.st = fat12_pkg::ST_BAD;
                            break;
                        end
                        if (steps >= Entries)
                        begin
                            r.st = fat12_pkg::ST_LIMIT;
                            break;
                        end
                        nxt = fat_mirror[cur];
                        fat_mirror[cur] = 12'd0;
                        cur = nxt;
                        steps++;
                    end
                    r.co = steps[12:0];
                end
                fat12_pkg::FN_SEEK:
                begin
                    while (steps < op.cnt)
                    begin
                        if (steps >= Entries)
                        begin
                            r.st = fat12_pkg::ST_LIMIT;
                            break;
                        end
                        k = link_class(cur);
                        if (k != fat12_pkg::K_LINK)
                        begin
                            if (k == fat12_pkg::K_BAD)
                                r.st = fat12_pkg::ST_BAD;
                            break;
                        end
                        cur = fat_mirror[cur];
                        steps++;
                    end
                    r.clo = cur;
                    r.co = steps[12:0];
                end
                fat12_pkg::FN_TAIL:
                begin
                    forever
                    begin
                        k = link_class(cur);
                        if (k == fat12_pkg::K_END)
                            break;
                        if (k == fat12_pkg::K_BAD)
                        begin
                            r.st = fat12_pkg::ST_BAD;
                            break;
                        end
                        if (steps >= Entries)
                        begin
                            r.st = fat12_pkg::ST_LIMIT;
                            break;
                        end
                        prev = cur;
                        cur = fat_mirror[cur];
                        steps++;
                    end
                    r.clo = prev;
                    r.co = steps[12:0];
                end
                fat12_pkg::FN_RUN:
                begin
                    k = link_class(cur);
                    r.clo = cur;
                    if (k == fat12_pkg::K_BAD)
                        r.st = fat12_pkg::ST_BAD;
                    else if (k == fat12_pkg::K_LINK && op.cnt > 0)
                    begin
                        steps = 1;
                        while (steps < op.cnt)
                        begin
                            nxt = fat_mirror[cur];
                            if ({1'b0, nxt} != {1'b0, cur} + 13'd1
                                || link_class(nxt) != fat12_pkg::K_LINK)
                                break;
                            cur = nxt;
                            steps++;
                        end
                        r.clo = cur;
                        r.co = steps[12:0];
                    end
                end
                default:
                    r = '{fat12_pkg::ST_OK, 12'd0, 12'd0, 13'd0};
            endcase
        end
        return r;
    endfunction

    task automatic add_row(input fat12_pkg::func_t fn, input int cl, input int val,
                           input int cnt, input bit typed, input fat12_pkg::status_t st,
                           input int clo, input int vo, input int co);
        fat_op_t op;
        op.fn = fn;
        op.cl = cl[11:0];
        op.val = val[11:0];
        op.cnt = cnt[11:0];
        op.typed = typed;
        op.res = '{st, clo[11:0], vo[11:0], co[12:0]};
        directed_ops.push_back(op);
    endtask

    task automatic send_op(input fat_op_t op);
        fat_result_t r;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, op.cnt, op.val, op.cl, op.fn};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = apply_fat_op(op);
        pending_results.push_back(op.typed ? op.res : r);
        ops_accepted++;
    endtask

    task automatic idle_gap(input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic idx, input int data);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data[12:0];
        @(posedge clk);
        if (idx == fat12_pkg::RegLimit)
            mirror_limit = data[12:0];
        else
            mirror_wen = data[0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [11:0] pick_cluster();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 75)
            return 12'($urandom_range(0, 70));
        else if (sel < 85)
            return 12'($urandom_range(4088, 4095));
        return 12'($urandom);
    endfunction

    function automatic fat_op_t random_op();
        fat_op_t op;
        int      sel;
        op.typed = 1'b0;
        op.res = '0;
        sel = $urandom_range(0, 99);
        if (sel < 14)
            op.fn = fat12_pkg::FN_READ;
        else if (sel < 30)
            op.fn = fat12_pkg::FN_WRITE;
        else if (sel < 58)
            op.fn = fat12_pkg::FN_ALLOC;
        else if (sel < 68)
            op.fn = fat12_pkg::FN_FREE;
        else if (sel < 77)
            op.fn = fat12_pkg::FN_SEEK;
        else if (sel < 86)
            op.fn = fat12_pkg::FN_TAIL;
        else if (sel < 97)
            op.fn = fat12_pkg::FN_RUN;
        else
            op.fn = fat12_pkg::FN_NONE;
        op.cl = pick_cluster();
        sel = $urandom_range(0, 99);
        if (sel < 40)
            op.val = 12'd0;
        else if (sel < 60)
            op.val = fat12_pkg::EndMark + 12'($urandom_range(0, 7));
        else if (sel < 80)
            op.val = 12'($urandom_range(2, 70));
        else if (sel < 90)
            op.val = (sel < 85) ? 12'd1 : fat12_pkg::BadMark;
        else
            op.val = 12'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 50)
            op.cnt = 12'($urandom_range(0, 8));
        else if (sel < 80)
            op.cnt = 12'($urandom);
        else
            op.cnt = (sel < 90) ? 12'hFFF : 12'd0;
        return op;
    endfunction

    initial
    begin
        int      mode;
        int      left;
        int      hold;
        m_axis_tready = 1'b0;
        mode = 0;
        left = 0;
        hold = 0;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && ops_accepted >= 4500)
            begin
                hold_done = 1'b1;
                hold = LongHold;
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(16, 96);
            end
            left--;
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (mode == 0)
                m_axis_tready <= 1'b1;
            else if (mode == 1)
                m_axis_tready <= 1'($urandom_range(0, 1));
            else
                m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk)
    begin
        fat_result_t got;
        fat_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.st = fat12_pkg::status_t'(m_axis_tdata[2:0]);
            got.clo = m_axis_tdata[14:3];
            got.vo = m_axis_tdata[26:15];
            got.co = m_axis_tdata[39:27];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.st !== want.st || got.clo !== want.clo || got.vo !== want.vo
                    || got.co !== want.co)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected st=%0d cl=%h val=%h cnt=%0d, ",
                                  "got st=%0d cl=%h val=%h cnt=%0d"},
                                 want.st, want.clo, want.vo, want.co,
                                 got.st, got.clo, got.vo, got.co);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IdleLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        fat_op_t op;
        int      burst;
        int      i;
        int      p;
        int      limits [7];
        int      wens [7];
        limits = '{4096, 16, 2, 4096, 100, 3000, 4096};
        wens = '{1, 1, 1, 0, 1, 1, 1};
        mismatches = 0;
        ops_accepted = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = 1'b0;
        cfg_wdata = '0;
        mirror_limit = fat12_pkg::LimitReset;
        mirror_wen = 1'b1;
        foreach (fat_mirror[j])
            fat_mirror[j] = 12'd0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(fat12_pkg::RegLimit, 4096);
        write_reg(fat12_pkg::RegWen, 1);
        for (i = 0; i < Entries; i++)
        begin
            op = '0;
            op.fn = fat12_pkg::FN_WRITE;
            op.cl = i[11:0];
            send_op(op);
            if ($urandom_range(0, 7) == 0)
                idle_gap($urandom_range(1, 4));
        end

        add_row(fat12_pkg::FN_READ,  0,     0,     0,    1, fat12_pkg::ST_OK,  0,     0,    0);
        add_row(fat12_pkg::FN_READ,  4095,  0,     0,    1, fat12_pkg::ST_OK,  4095,  0,    0);
        add_row(fat12_pkg::FN_WRITE, 4095,  4095,  0,    1, fat12_pkg::ST_OK,  4095,  0,    0);
        add_row(fat12_pkg::FN_READ,  4095,  0,     0,    1, fat12_pkg::ST_OK,  4095,  4095, 0);
        add_row(fat12_pkg::FN_ALLOC, 0,     0,     0,    1, fat12_pkg::ST_OK,  2,     0,    0);
        add_row(fat12_pkg::FN_ALLOC, 2,     0,     0,    1, fat12_pkg::ST_OK,  3,     0,    0);
        add_row(fat12_pkg::FN_ALLOC, 3,     4095,  4095, 1, fat12_pkg::ST_OK,  4,     0,    0);
        add_row(fat12_pkg::FN_TAIL,  2,     0,     0,    1, fat12_pkg::ST_OK,  4,     0,    3);
        add_row(fat12_pkg::FN_SEEK,  2,     0,     1,    0, fat12_pkg::ST_OK,  0,     0,    0);
        add_row(fat12_pkg::FN_SEEK,  2,     0,     4095, 1, fat12_pkg::ST_OK,  'hFF8, 0,    3);
        add_row(fat12_pkg::FN_SEEK,  2,     0,     0,    1, fat12_pkg::ST_OK,  2,     0,    0);
        add_row(fat12_pkg::FN_RUN,   2,     0,     4095, 1, fat12_pkg::ST_OK,  4,     0,    3);
        add_row(fat12_pkg::FN_RUN,   2,     0,     0,    1, fat12_pkg::ST_OK,  2,     0,    0);
        add_row(fat12_pkg::FN_RUN,   0,     0,     5,    1, fat12_pkg::ST_OK,  0,     0,    0);
        add_row(fat12_pkg::FN_RUN,   1,     0,     5,    1, fat12_pkg::ST_BAD, 1,     0,    0);
        add_row(fat12_pkg::FN_ALLOC, 1,     0,     0,    1, fat12_pkg::ST_BAD, 0,     0,    0);
        add_row(fat12_pkg::FN_ALLOC, 'hFF7, 0,     0,    1, fat12_pkg::ST_BAD, 0,     0,    0);
        add_row(fat12_pkg::FN_ALLOC, 4095,  0,     0,    1, fat12_pkg::ST_BAD, 0,     0,    0);
        add_row(fat12_pkg::FN_WRITE, 5,     'hFF7, 0,    0, fat12_pkg::ST_OK,  0,     0,    0);
        add_row(fat12_pkg::FN_SEEK,  5,     0,     2,    1, fat12_pkg::ST_BAD, 'hFF7, 0,    1);
        add_row(fat12_pkg::FN_TAIL,  5,     0,     0,    1, fat12_pkg::ST_BAD, 5,     0,    1);
        add_row(fat12_pkg::FN_FREE,  5,     0,     0,    1, fat12_pkg::ST_BAD, 0,     0,    1);
        add_row(fat12_pkg::FN_FREE,  2,     0,     0,    1, fat12_pkg::ST_OK,  0,     0,    3);
        add_row(fat12_pkg::FN_NONE,  4095,  4095,  4095, 1, fat12_pkg::ST_OK,  0,     0,    0);
        add_row(fat12_pkg::FN_TAIL,  0,     0,     0,    1, fat12_pkg::ST_OK,  0,     0,    0);
        foreach (directed_ops[j])
        begin
            send_op(directed_ops[j]);
            if ($urandom_range(0, 2) == 0)
                idle_gap($urandom_range(1, 3));
        end

        for (p = 0; p < 7; p++)
        begin
            write_reg(fat12_pkg::RegLimit, limits[p]);
            write_reg(fat12_pkg::RegWen, wens[p]);
            i = 0;
            while (i < PhaseItems)
            begin
                burst = $urandom_range(1, 20);
                repeat (burst)
                begin
                    send_op(random_op());
                    i++;
                end
                if ($urandom_range(0, 3) != 0)
                    idle_gap($urandom_range(1, 10));
            end
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (50)
            @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
